// File: rtl/lhts_pkg.sv
// ---------------------------------------------------------------------------
// lhts_pkg: shared types and constants of the line hit test select unit
// Default widths, register indexes, reason codes and the stage control bundle.
// ---------------------------------------------------------------------------
package lhts_pkg;

  localparam int CoordBitsDef = 16;
  localparam int LineBitsDef  = 12;
  localparam int CfgIdxBits   = 1;
  localparam int ReasonBits   = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_POINT_X = 1'b0,
    CFG_POINT_Y = 1'b1
  } cfg_reg_e;

  typedef enum logic [ReasonBits-1:0] {
    RSN_INSIDE    = 3'd0,
    RSN_BESIDE    = 3'd1,
    RSN_BELOW_GAP = 3'd2,
    RSN_BELOW_ALL = 3'd3,
    RSN_NONE      = 3'd4
  } reason_e;

  // control from the input register to the tracker and the result register
  typedef struct packed {
    logic step;
    logic present;
    logic last;
  } lhts_ctl_t;

endpackage

// File: rtl/lhts_if.sv
// ---------------------------------------------------------------------------
// lhts_if: channel interfaces of the line hit test select unit
// Word beat input, result output and configuration write channel.
// ---------------------------------------------------------------------------
interface lhts_word_if #(
  parameter int CoordBits = lhts_pkg::CoordBitsDef,
  parameter int LineBits  = lhts_pkg::LineBitsDef
);
  logic                        valid;
  logic                        ready;
  logic                        present;
  logic signed [LineBits:0]    line;
  logic signed [CoordBits-1:0] box_left;
  logic signed [CoordBits-1:0] box_top;
  logic signed [CoordBits-1:0] box_right;
  logic signed [CoordBits-1:0] box_bottom;
  logic                        last_word;

  modport source (output valid, present, line, box_left, box_top, box_right,
                  box_bottom, last_word, input ready);
  modport sink   (input valid, present, line, box_left, box_top, box_right,
                  box_bottom, last_word, output ready);
endinterface

interface lhts_result_if #(
  parameter int LineBits = lhts_pkg::LineBitsDef
);
  logic                     valid;
  logic                     ready;
  logic signed [LineBits:0] chosen_line;
  lhts_pkg::reason_e        reason;

  modport source (output valid, chosen_line, reason, input ready);
  modport sink   (input valid, chosen_line, reason, output ready);
endinterface

interface lhts_cfg_if #(
  parameter int CoordBits = lhts_pkg::CoordBitsDef
);
  logic                              valid;
  logic                              ready;
  logic [lhts_pkg::CfgIdxBits-1:0]   index;
  logic [CoordBits-1:0]              data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/lhts_in_stage.sv
// ---------------------------------------------------------------------------
// lhts_in_stage: input register of the line hit test select unit
// Captures one word beat per cycle, except while a closing beat waits, and hands it to the tracker.
// ---------------------------------------------------------------------------
module lhts_in_stage #(
  parameter int COORD_BITS = lhts_pkg::CoordBitsDef,
  parameter int LINE_BITS  = lhts_pkg::LineBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lhts_word_if.sink                    word_i,
  input  logic                         out_free_i,
  output lhts_pkg::lhts_ctl_t          ctl_o,
  output logic signed [LINE_BITS:0]    line_o,
  output logic signed [COORD_BITS-1:0] left_o,
  output logic signed [COORD_BITS-1:0] top_o,
  output logic signed [COORD_BITS-1:0] right_o,
  output logic signed [COORD_BITS-1:0] bottom_o
);
  import lhts_pkg::*;

  logic                         vld_q;
  logic                         present_q;
  logic                         last_q;
  logic signed [LINE_BITS:0]    line_q;
  logic signed [COORD_BITS-1:0] left_q;
  logic signed [COORD_BITS-1:0] top_q;
  logic signed [COORD_BITS-1:0] right_q;
  logic signed [COORD_BITS-1:0] bottom_q;
  logic                         step;
  logic                         take;

  // a closing beat waits here while the result register is full and not taken
  assign step         = vld_q && (!last_q || out_free_i);
  assign word_i.ready = !vld_q || step;
  assign take         = word_i.valid && word_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (word_i.ready) begin
      vld_q <= word_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      present_q <= word_i.present;
      last_q    <= word_i.last_word;
      line_q    <= word_i.line;
      left_q    <= word_i.box_left;
      top_q     <= word_i.box_top;
      right_q   <= word_i.box_right;
      bottom_q  <= word_i.box_bottom;
    end
  end

  assign ctl_o.step    = step;
  assign ctl_o.present = present_q;
  assign ctl_o.last    = last_q;
  assign line_o        = line_q;
  assign left_o        = left_q;
  assign top_o         = top_q;
  assign right_o       = right_q;
  assign bottom_o      = bottom_q;

endmodule

// File: rtl/lhts_tracker.sv
// ---------------------------------------------------------------------------
// lhts_tracker: candidate tracking of the line hit test select unit
// Holds the point registers and the hit, beside, below and lowest candidates,
// updates them from one word per cycle while the input register steps and forms the answer at list end.
// ---------------------------------------------------------------------------
module lhts_tracker #(
  parameter int COORD_BITS = lhts_pkg::CoordBitsDef,
  parameter int LINE_BITS  = lhts_pkg::LineBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lhts_cfg_if.sink                     cfg_i,
  input  lhts_pkg::lhts_ctl_t          ctl_i,
  input  logic signed [LINE_BITS:0]    line_i,
  input  logic signed [COORD_BITS-1:0] left_i,
  input  logic signed [COORD_BITS-1:0] top_i,
  input  logic signed [COORD_BITS-1:0] right_i,
  input  logic signed [COORD_BITS-1:0] bottom_i,
  output logic signed [LINE_BITS:0]    res_line_o,
  output lhts_pkg::reason_e            res_reason_o
);
  import lhts_pkg::*;

  localparam logic [COORD_BITS:0] One = (COORD_BITS+1)'(1);

  logic signed [COORD_BITS-1:0] px_q, py_q;

  logic                         hit_found_q, hit_found_d, hit_found_u;
  logic [LINE_BITS-1:0]         hit_line_q, hit_line_d, hit_line_u;
  logic                         beside_vld_q, beside_vld_d, beside_vld_u;
  logic [LINE_BITS-1:0]         beside_line_q, beside_line_d, beside_line_u;
  logic signed [COORD_BITS-1:0] beside_top_q, beside_top_d, beside_top_u;
  logic                         below_vld_q, below_vld_d, below_vld_u;
  logic [LINE_BITS-1:0]         below_line_q, below_line_d, below_line_u;
  logic signed [COORD_BITS-1:0] below_top_q, below_top_d, below_top_u;
  logic                         lowest_vld_q, lowest_vld_d, lowest_vld_u;
  logic [LINE_BITS-1:0]         lowest_line_q, lowest_line_d, lowest_line_u;
  logic signed [COORD_BITS-1:0] lowest_top_q, lowest_top_d, lowest_top_u;

  logic [COORD_BITS:0]  left_x, top_x, right_x, bottom_x;
  logic                 is_null, word_ok, in_span, in_x;
  logic [LINE_BITS-1:0] word_line;
  logic                 clear;

  // point registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0;
      py_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_POINT_X: px_q <= cfg_i.data;
        CFG_POINT_Y: py_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // null box test one bit wider so that left minus one cannot wrap
  assign left_x    = {left_i[COORD_BITS-1], left_i};
  assign top_x     = {top_i[COORD_BITS-1], top_i};
  assign right_x   = {right_i[COORD_BITS-1], right_i};
  assign bottom_x  = {bottom_i[COORD_BITS-1], bottom_i};
  assign is_null   = (right_x == left_x - One) && (bottom_x == top_x - One);
  assign word_ok   = ctl_i.present && !line_i[LINE_BITS] && !is_null;
  assign word_line = line_i[LINE_BITS-1:0];
  assign in_span   = (py_q >= top_i) && (py_q <= bottom_i);
  assign in_x      = (px_q >= left_i) && (px_q <= right_i);
  assign clear     = ctl_i.step && ctl_i.last;

  always_comb begin
    hit_found_u   = hit_found_q;
    hit_line_u    = hit_line_q;
    beside_vld_u  = beside_vld_q;
    beside_line_u = beside_line_q;
    beside_top_u  = beside_top_q;
    below_vld_u   = below_vld_q;
    below_line_u  = below_line_q;
    below_top_u   = below_top_q;
    lowest_vld_u  = lowest_vld_q;
    lowest_line_u = lowest_line_q;
    lowest_top_u  = lowest_top_q;
    if (word_ok) begin
      if (!lowest_vld_q || top_i > lowest_top_q) begin
        lowest_vld_u  = 1'b1;
        lowest_line_u = word_line;
        lowest_top_u  = top_i;
      end
      if (!hit_found_q) begin
        priority if (in_span && in_x) begin
          hit_found_u = 1'b1;
          hit_line_u  = word_line;
        end else if (in_span) begin
          if (!beside_vld_q || top_i < beside_top_q) begin
            beside_vld_u  = 1'b1;
            beside_line_u = word_line;
            beside_top_u  = top_i;
          end
        end else begin
          if (top_i > py_q && (!below_vld_q || top_i < below_top_q)) begin
            below_vld_u  = 1'b1;
            below_line_u = word_line;
            below_top_u  = top_i;
          end
        end
      end
    end
  end

  // answer includes the closing word itself
  always_comb begin
    priority if (hit_found_u) begin
      res_line_o   = {1'b0, hit_line_u};
      res_reason_o = RSN_INSIDE;
    end else if (beside_vld_u) begin
      res_line_o   = {1'b0, beside_line_u};
      res_reason_o = RSN_BESIDE;
    end else if (below_vld_u) begin
      res_line_o   = {1'b0, below_line_u};
      res_reason_o = RSN_BELOW_GAP;
    end else if (lowest_vld_u) begin
      res_line_o   = {1'b0, lowest_line_u};
      res_reason_o = RSN_BELOW_ALL;
    end else begin
      res_line_o   = '1;
      res_reason_o = RSN_NONE;
    end
  end

  always_comb begin
    hit_found_d   = hit_found_q;
    beside_vld_d  = beside_vld_q;
    below_vld_d   = below_vld_q;
    lowest_vld_d  = lowest_vld_q;
    hit_line_d    = hit_line_q;
    beside_line_d = beside_line_q;
    beside_top_d  = beside_top_q;
    below_line_d  = below_line_q;
    below_top_d   = below_top_q;
    lowest_line_d = lowest_line_q;
    lowest_top_d  = lowest_top_q;
    if (ctl_i.step) begin
      hit_found_d   = hit_found_u && !ctl_i.last;
      beside_vld_d  = beside_vld_u && !ctl_i.last;
      below_vld_d   = below_vld_u && !ctl_i.last;
      lowest_vld_d  = lowest_vld_u && !ctl_i.last;
      hit_line_d    = hit_line_u;
      beside_line_d = beside_line_u;
      beside_top_d  = beside_top_u;
      below_line_d  = below_line_u;
      below_top_d   = below_top_u;
      lowest_line_d = lowest_line_u;
      lowest_top_d  = lowest_top_u;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_found_q  <= 1'b0;
      beside_vld_q <= 1'b0;
      below_vld_q  <= 1'b0;
      lowest_vld_q <= 1'b0;
    end else begin
      hit_found_q  <= hit_found_d;
      beside_vld_q <= beside_vld_d;
      below_vld_q  <= below_vld_d;
      lowest_vld_q <= lowest_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_line_q    <= hit_line_d;
    beside_line_q <= beside_line_d;
    beside_top_q  <= beside_top_d;
    below_line_q  <= below_line_d;
    below_top_q   <= below_top_d;
    lowest_line_q <= lowest_line_d;
    lowest_top_q  <= lowest_top_d;
  end

  // every candidate list ends with all candidates dropped
  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> !hit_found_q && !beside_vld_q && !below_vld_q && !lowest_vld_q)
    else $error("candidates survive the end of a list");

  // a hit stays until the list closes
  a_hit_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_found_q && !clear |=> hit_found_q)
    else $error("hit dropped inside a list");

  // any usable word also feeds the lowest candidate
  a_lowest_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_found_q || beside_vld_q || below_vld_q |-> lowest_vld_q)
    else $error("candidate held without a lowest candidate");

  // once hit, the beside and below candidates are frozen
  a_hit_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_found_q && !clear |=> $stable(beside_vld_q) && $stable(below_vld_q))
    else $error("fallback candidate changed after a hit");

endmodule

// File: rtl/lhts_out_stage.sv
// ---------------------------------------------------------------------------
// lhts_out_stage: result register of the line hit test select unit
// Holds one answer until the sink takes it.
// ---------------------------------------------------------------------------
module lhts_out_stage #(
  parameter int LINE_BITS = lhts_pkg::LineBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lhts_pkg::lhts_ctl_t       ctl_i,
  input  logic signed [LINE_BITS:0] res_line_i,
  input  lhts_pkg::reason_e         res_reason_i,
  output logic                      out_free_o,
  lhts_result_if.source             res_o
);
  import lhts_pkg::*;

  logic                      valid_q, valid_d;
  logic signed [LINE_BITS:0] line_q;
  reason_e                   reason_q;
  logic                      load;

  assign load       = ctl_i.step && ctl_i.last;
  assign out_free_o = !valid_q || res_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      line_q   <= res_line_i;
      reason_q <= res_reason_i;
    end
  end

  assign res_o.valid       = valid_q;
  assign res_o.chosen_line = line_q;
  assign res_o.reason      = reason_q;

endmodule

// File: rtl/line_hit_test_select_unit.sv
// ---------------------------------------------------------------------------
// line_hit_test_select_unit: picks the text line a configured point selects
// Streams word boxes, tracks hit / beside / below / lowest candidates and
// answers once per list on its closing beat.
// ---------------------------------------------------------------------------
//  channel  | dir | payload                                         | beat
//  in_i     | in  | present line box_left/top/right/bottom last_word | one word
//  out_o    | out | chosen_line reason                              | one answer
//  cfg_i    | in  | index data (point_x, point_y)                   | one write
//
// one word beat per cycle, except while a closing beat waits; input register, then the candidate
// compare into the state and result registers
// the answer of a taken closing beat goes from the input register into the result register, which drives out_o
// reset clears the candidates, the point to zero and both valid flags
// a closing beat stalls in the input register only while out_o holds an
// answer that is not taken; other beats keep flowing
// ---------------------------------------------------------------------------
module line_hit_test_select_unit #(
  parameter int COORD_BITS = lhts_pkg::CoordBitsDef,
  parameter int LINE_BITS  = lhts_pkg::LineBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lhts_word_if.sink     in_i,
  lhts_result_if.source out_o,
  lhts_cfg_if.sink      cfg_i
);
  import lhts_pkg::*;

  lhts_ctl_t                    ctl;
  logic                         out_free;
  logic signed [LINE_BITS:0]    s1_line;
  logic signed [COORD_BITS-1:0] s1_left, s1_top, s1_right, s1_bottom;
  logic signed [LINE_BITS:0]    res_line;
  reason_e                      res_reason;

  lhts_in_stage #(
    .COORD_BITS(COORD_BITS),
    .LINE_BITS (LINE_BITS)
  ) u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .word_i    (in_i),
    .out_free_i(out_free),
    .ctl_o     (ctl),
    .line_o    (s1_line),
    .left_o    (s1_left),
    .top_o     (s1_top),
    .right_o   (s1_right),
    .bottom_o  (s1_bottom)
  );

  lhts_tracker #(
    .COORD_BITS(COORD_BITS),
    .LINE_BITS (LINE_BITS)
  ) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .ctl_i       (ctl),
    .line_i      (s1_line),
    .left_i      (s1_left),
    .top_i       (s1_top),
    .right_i     (s1_right),
    .bottom_i    (s1_bottom),
    .res_line_o  (res_line),
    .res_reason_o(res_reason)
  );

  lhts_out_stage #(
    .LINE_BITS(LINE_BITS)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .res_line_i  (res_line),
    .res_reason_i(res_reason),
    .out_free_o  (out_free),
    .res_o       (out_o)
  );

endmodule
